// File: hw/rtl/dre_pkg.sv
// Shared types, constants and modular helpers for the double rolling hash engine.
package dre_pkg;

    localparam int HASH_W      = 30;
    localparam int CHAR_W      = 8;
    localparam int MAX_LEN_DEF = 4096;

    localparam logic [HASH_W-1:0] BASE_ONE = 30'd1007;
    localparam logic [HASH_W-1:0] BASE_TWO = 30'd2009;
    localparam logic [HASH_W-1:0] MOD_ONE  = 30'd1000000007;
    localparam logic [HASH_W-1:0] MOD_TWO  = 30'd1000000009;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_FINISH = 3'd2,
        OP_RANGE  = 3'd3,
        OP_PALIN  = 3'd4,
        OP_LCP    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_RANGE  = 2'd1,
        ST_FULL       = 2'd2,
        ST_NO_REVERSE = 2'd3
    } st_t;

    typedef enum logic [1:0] {
        MM_RANGE = 2'd0,
        MM_FWD   = 2'd1,
        MM_POW   = 2'd2,
        MM_REV   = 2'd3
    } mm_sel_t;

    typedef enum logic [1:0] {
        RS_AB  = 2'd0,
        RS_REV = 2'd1,
        RS_LA  = 2'd2,
        RS_LB  = 2'd3
    } rsrc_t;

    typedef enum logic [2:0] {
        PH_Q   = 3'd0,
        PH_REV = 3'd1,
        PH_FWD = 3'd2,
        PH_LA  = 3'd3,
        PH_LB  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APP_F,
        S_APP_P,
        S_REV_CHK,
        S_REV_RD,
        S_REV_MM,
        S_RD_LP,
        S_RD_R,
        S_MM_R,
        S_MM_W,
        S_POST,
        S_LCP_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    set_status;
        st_t     st_val;
        logic    ld_range;
        rsrc_t   range_src;
        logic    hsel_r;
        logic    cap_lp;
        logic    cap_r;
        logic    mm_start;
        mm_sel_t mm_sel;
        logic    range_save;
        logic    save_x;
        logic    set_hash;
        logic    set_pal;
        logic    lcp_init;
        logic    lcp_upd;
        logic    set_plen;
        logic    app_fwd;
        logic    app_pow;
        logic    rev_start;
        logic    rev_rd;
        logic    rev_wr;
        logic    rev_done;
        logic    rev_off;
        logic    out_load;
    } dre_cmd_t;

    typedef struct packed {
        op_t  op;
        logic range_ok;
        logic lcp_ok;
        logic full;
        logic ren;
        logic rdy;
        logic mm_done;
        logic lcp_more;
        logic eq;
        logic rev_end;
        logic out_busy;
    } dre_sts_t;

    function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] x,
                                                  input logic [HASH_W-1:0] y,
                                                  input logic [HASH_W-1:0] m);
        logic [HASH_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[HASH_W-1:0];
    endfunction

    // (x - y) mod m for x, y below m
    function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] x,
                                                  input logic [HASH_W-1:0] y,
                                                  input logic [HASH_W-1:0] m);
        logic [HASH_W-1:0] ny;
        ny = m - y;
        return add_mod(x, ny, m);
    endfunction

endpackage

// File: hw/rtl/dre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dre_modmul.sv
// Bit-serial modular multiplier: one bit of the first operand per cycle.
module dre_modmul #(
    parameter logic [dre_pkg::HASH_W-1:0] MOD = dre_pkg::MOD_ONE
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dre_pkg::HASH_W-1:0] op_a,
    input  logic [dre_pkg::HASH_W-1:0] op_b,
    output logic                       done,
    output logic [dre_pkg::HASH_W-1:0] prod
);
    import dre_pkg::*;

    localparam int CNT_W = $clog2(HASH_W + 1);

    logic                run_reg,  run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic [HASH_W-1:0]   a_reg,    a_next;
    logic [HASH_W-1:0]   b_reg,    b_next;
    logic [HASH_W-1:0]   acc_reg,  acc_next;
    logic [HASH_W:0]     dbl;
    logic [HASH_W-1:0]   dbl_m;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        dbl       = {acc_reg, 1'b0};
        if (dbl >= {1'b0, MOD})
        begin
            dbl = dbl - {1'b0, MOD};
        end
        dbl_m = dbl[HASH_W-1:0];
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(HASH_W);
            a_next   = op_a;
            b_next   = op_b;
            acc_next = '0;
        end
        else if (run_reg)
        begin
            // double, then add b when the top bit of a is set
            acc_next = a_reg[HASH_W-1] ? add_mod(dbl_m, b_reg, MOD) : dbl_m;
            a_next   = {a_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: hw/rtl/dre_dp.sv
// Datapath: hash stores, modular multipliers, range and search registers, result registers.
module dre_dp #(
    parameter int MAX_LEN = dre_pkg::MAX_LEN_DEF,
    localparam int LW     = $clog2(MAX_LEN + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dre_pkg::dre_cmd_t          cmd,
    output dre_pkg::dre_sts_t          sts,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic [2:0]                 opcode,
    input  logic [dre_pkg::CHAR_W-1:0] char_value,
    input  logic [LW-1:0]              pos_a,
    input  logic [LW-1:0]              pos_b,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dre_pkg::HASH_W-1:0] hash_first,
    output logic [dre_pkg::HASH_W-1:0] hash_second,
    output logic                       is_palin,
    output logic [LW-1:0]              prefix_length,
    output logic [1:0]                 status
);
    import dre_pkg::*;

    localparam int CW  = LW + 1;
    localparam int BAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int HD  = MAX_LEN + 1;

    op_t               op_reg;
    logic [CHAR_W-1:0] ch_reg, byte_reg;
    logic [LW-1:0]     a_reg, b_reg, len_reg, rl_reg, rr_reg, mid_reg, idx_reg;
    logic              rdy_reg, ren_reg, rev_reg, hz_reg, pz_reg, ov_reg;
    logic [CW-1:0]     lo_reg, hi_reg;
    logic [HASH_W-1:0] hl1_reg, hl2_reg, pw1_reg, pw2_reg, hr1_reg, hr2_reg;
    logic [HASH_W-1:0] rh1_reg, rh2_reg, x1_reg, x2_reg;
    logic [HASH_W-1:0] lf1_reg, lf2_reg, lp1_reg, lp2_reg, rv1_reg, rv2_reg;
    logic [HASH_W-1:0] res_h1_reg, res_h2_reg, oh1_reg, oh2_reg;
    logic              res_pal_reg, opal_reg;
    logic [LW-1:0]     res_plen_reg, oplen_reg;
    st_t               res_st_reg, ost_reg;

    logic [LW-1:0]     haddr, paddr, len_inc, idx_inc, brd, mx, mid_c;
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     hi_init;
    logic [HASH_W-1:0] fwd1_q, fwd2_q, rev1_q, rev2_q, pow1_q, pow2_q;
    logic [CHAR_W-1:0] byte_q;
    logic [HASH_W-1:0] hv1, hv2, pv1, pv2;
    logic [HASH_W-1:0] ma1, ma2, mb1, mb2, mm1, mm2;
    logic [HASH_W-1:0] nf1, nf2, nr1, nr2, sh1, sh2;
    logic              mm_done1, mm_done2;

    assign haddr   = cmd.hsel_r ? rr_reg : rl_reg;
    assign paddr   = rr_reg - rl_reg;
    assign len_inc = len_reg + LW'(1);
    assign idx_inc = idx_reg + LW'(1);
    assign brd     = len_reg - LW'(1) - idx_reg;
    assign mx      = (a_reg > b_reg) ? a_reg : b_reg;
    assign hi_init = CW'(len_reg) + CW'(1) - CW'(mx);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW+1)'(1);
    assign mid_c   = mid_sum[LW:1];

    // index 0 of each hash table is fixed and never written
    assign hv1 = hz_reg ? '0 : (rev_reg ? rev1_q : fwd1_q);
    assign hv2 = hz_reg ? '0 : (rev_reg ? rev2_q : fwd2_q);
    assign pv1 = pz_reg ? HASH_W'(1) : pow1_q;
    assign pv2 = pz_reg ? HASH_W'(1) : pow2_q;

    always_comb
    begin
        case (cmd.mm_sel)
            MM_RANGE:
            begin
                ma1 = hl1_reg; ma2 = hl2_reg; mb1 = pw1_reg; mb2 = pw2_reg;
            end
            MM_FWD:
            begin
                ma1 = lf1_reg; ma2 = lf2_reg; mb1 = BASE_ONE; mb2 = BASE_TWO;
            end
            MM_POW:
            begin
                ma1 = lp1_reg; ma2 = lp2_reg; mb1 = BASE_ONE; mb2 = BASE_TWO;
            end
            default:
            begin
                ma1 = rv1_reg; ma2 = rv2_reg; mb1 = BASE_ONE; mb2 = BASE_TWO;
            end
        endcase
    end

    assign nf1 = add_mod(mm1, HASH_W'(ch_reg), MOD_ONE);
    assign nf2 = add_mod(mm2, HASH_W'(ch_reg), MOD_TWO);
    assign nr1 = add_mod(mm1, HASH_W'(byte_reg), MOD_ONE);
    assign nr2 = add_mod(mm2, HASH_W'(byte_reg), MOD_TWO);
    assign sh1 = sub_mod(hr1_reg, mm1, MOD_ONE);
    assign sh2 = sub_mod(hr2_reg, mm2, MOD_TWO);

    dre_modmul #(.MOD(MOD_ONE)) u_mm1 (
        .clk(clk), .rst_n(rst_n), .start(cmd.mm_start),
        .op_a(ma1), .op_b(mb1), .done(mm_done1), .prod(mm1)
    );
    dre_modmul #(.MOD(MOD_TWO)) u_mm2 (
        .clk(clk), .rst_n(rst_n), .start(cmd.mm_start),
        .op_a(ma2), .op_b(mb2), .done(mm_done2), .prod(mm2)
    );

    dre_ram #(.WIDTH(HASH_W), .DEPTH(HD)) u_fwd1 (
        .clk(clk), .we(cmd.app_fwd), .waddr(len_inc), .wdata(nf1),
        .raddr(haddr), .rdata(fwd1_q)
    );
    dre_ram #(.WIDTH(HASH_W), .DEPTH(HD)) u_fwd2 (
        .clk(clk), .we(cmd.app_fwd), .waddr(len_inc), .wdata(nf2),
        .raddr(haddr), .rdata(fwd2_q)
    );
    dre_ram #(.WIDTH(HASH_W), .DEPTH(HD)) u_pow1 (
        .clk(clk), .we(cmd.app_pow), .waddr(len_inc), .wdata(mm1),
        .raddr(paddr), .rdata(pow1_q)
    );
    dre_ram #(.WIDTH(HASH_W), .DEPTH(HD)) u_pow2 (
        .clk(clk), .we(cmd.app_pow), .waddr(len_inc), .wdata(mm2),
        .raddr(paddr), .rdata(pow2_q)
    );
    dre_ram #(.WIDTH(HASH_W), .DEPTH(HD)) u_rev1 (
        .clk(clk), .we(cmd.rev_wr), .waddr(idx_inc), .wdata(nr1),
        .raddr(haddr), .rdata(rev1_q)
    );
    dre_ram #(.WIDTH(HASH_W), .DEPTH(HD)) u_rev2 (
        .clk(clk), .we(cmd.rev_wr), .waddr(idx_inc), .wdata(nr2),
        .raddr(haddr), .rdata(rev2_q)
    );
    dre_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_bytes (
        .clk(clk), .we(cmd.app_fwd), .waddr(len_reg[BAW-1:0]), .wdata(ch_reg),
        .raddr(brd[BAW-1:0]), .rdata(byte_q)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            rdy_reg <= 1'b0;
            ren_reg <= 1'b0;
            ov_reg  <= 1'b0;
            lf1_reg <= '0;
            lf2_reg <= '0;
            lp1_reg <= HASH_W'(1);
            lp2_reg <= HASH_W'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                ren_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                len_reg <= '0;
                rdy_reg <= 1'b0;
                lf1_reg <= '0;
                lf2_reg <= '0;
                lp1_reg <= HASH_W'(1);
                lp2_reg <= HASH_W'(1);
            end
            if (cmd.app_fwd)
            begin
                lf1_reg <= nf1;
                lf2_reg <= nf2;
            end
            if (cmd.app_pow)
            begin
                lp1_reg <= mm1;
                lp2_reg <= mm2;
                len_reg <= len_inc;
                rdy_reg <= 1'b0;
            end
            if (cmd.rev_done)
            begin
                rdy_reg <= 1'b1;
            end
            if (cmd.rev_off)
            begin
                rdy_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        hz_reg <= (haddr == '0);
        pz_reg <= (paddr == '0);
        if (cmd.capture)
        begin
            op_reg       <= op_t'(opcode);
            ch_reg       <= char_value;
            a_reg        <= pos_a;
            b_reg        <= pos_b;
            res_h1_reg   <= '0;
            res_h2_reg   <= '0;
            res_pal_reg  <= 1'b0;
            res_plen_reg <= '0;
            res_st_reg   <= ST_OK;
        end
        if (cmd.set_status)
        begin
            res_st_reg <= cmd.st_val;
        end
        if (cmd.ld_range)
        begin
            case (cmd.range_src)
                RS_AB:
                begin
                    rl_reg <= a_reg; rr_reg <= b_reg; rev_reg <= 1'b0;
                end
                RS_REV:
                begin
                    rl_reg <= len_reg - b_reg; rr_reg <= len_reg - a_reg; rev_reg <= 1'b1;
                end
                RS_LA:
                begin
                    rl_reg <= a_reg; rr_reg <= a_reg + mid_c; rev_reg <= 1'b0;
                    mid_reg <= mid_c;
                end
                default:
                begin
                    rl_reg <= b_reg; rr_reg <= b_reg + mid_reg; rev_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.cap_lp)
        begin
            hl1_reg <= hv1; hl2_reg <= hv2;
            pw1_reg <= pv1; pw2_reg <= pv2;
        end
        if (cmd.cap_r)
        begin
            hr1_reg <= hv1; hr2_reg <= hv2;
        end
        if (cmd.range_save)
        begin
            rh1_reg <= sh1; rh2_reg <= sh2;
        end
        if (cmd.save_x)
        begin
            x1_reg <= rh1_reg; x2_reg <= rh2_reg;
        end
        if (cmd.set_hash)
        begin
            res_h1_reg <= rh1_reg; res_h2_reg <= rh2_reg;
        end
        if (cmd.set_pal)
        begin
            res_pal_reg <= sts.eq;
        end
        if (cmd.lcp_init)
        begin
            lo_reg <= '0;
            hi_reg <= hi_init;
        end
        if (cmd.lcp_upd)
        begin
            if (sts.eq)
            begin
                lo_reg <= CW'(mid_reg) + CW'(1);
            end
            else
            begin
                hi_reg <= CW'(mid_reg);
            end
        end
        if (cmd.set_plen)
        begin
            res_plen_reg <= (lo_reg == '0) ? '0 : LW'(lo_reg - CW'(1));
        end
        if (cmd.rev_start)
        begin
            rv1_reg <= '0; rv2_reg <= '0; idx_reg <= '0;
        end
        if (cmd.rev_rd)
        begin
            byte_reg <= byte_q;
        end
        if (cmd.rev_wr)
        begin
            rv1_reg <= nr1; rv2_reg <= nr2; idx_reg <= idx_inc;
        end
        if (cmd.out_load)
        begin
            oh1_reg   <= res_h1_reg;
            oh2_reg   <= res_h2_reg;
            opal_reg  <= res_pal_reg;
            oplen_reg <= res_plen_reg;
            ost_reg   <= res_st_reg;
        end
    end

    always_comb
    begin
        sts.op       = op_reg;
        sts.range_ok = (a_reg <= b_reg) && (b_reg <= len_reg);
        sts.lcp_ok   = (a_reg <= len_reg) && (b_reg <= len_reg);
        sts.full     = (len_reg >= LW'(MAX_LEN));
        sts.ren      = ren_reg;
        sts.rdy      = rdy_reg;
        sts.mm_done  = mm_done1 && mm_done2;
        sts.lcp_more = (hi_reg > lo_reg);
        sts.eq       = (rh1_reg == x1_reg) && (rh2_reg == x2_reg);
        sts.rev_end  = (idx_reg == len_reg);
        sts.out_busy = ov_reg && out_stall;
    end

    assign out_valid     = ov_reg;
    assign hash_first    = oh1_reg;
    assign hash_second   = oh2_reg;
    assign is_palin      = opal_reg;
    assign prefix_length = oplen_reg;
    assign status        = ost_reg;

endmodule

// File: hw/rtl/dre_ctrl.sv
// Controller: sequences each item's reads, multiplies and search steps.
module dre_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dre_pkg::dre_sts_t sts,
    output dre_pkg::dre_cmd_t cmd
);
    import dre_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_Q;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    OP_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st_val     = ST_FULL;
                        end
                        else
                        begin
                            cmd.mm_start = 1'b1;
                            cmd.mm_sel   = MM_FWD;
                            state_next   = S_APP_F;
                        end
                    end
                    OP_FINISH:
                    begin
                        if (sts.ren)
                        begin
                            cmd.rev_start = 1'b1;
                            state_next    = S_REV_CHK;
                        end
                        else
                        begin
                            cmd.rev_off = 1'b1;
                        end
                    end
                    OP_RANGE:
                    begin
                        if (!sts.range_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st_val     = ST_BAD_RANGE;
                        end
                        else
                        begin
                            cmd.ld_range  = 1'b1;
                            cmd.range_src = RS_AB;
                            phase_next    = PH_Q;
                            state_next    = S_RD_LP;
                        end
                    end
                    OP_PALIN:
                    begin
                        if (!sts.range_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st_val     = ST_BAD_RANGE;
                        end
                        else if (!sts.rdy)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st_val     = ST_NO_REVERSE;
                        end
                        else
                        begin
                            cmd.ld_range  = 1'b1;
                            cmd.range_src = RS_REV;
                            phase_next    = PH_REV;
                            state_next    = S_RD_LP;
                        end
                    end
                    OP_LCP:
                    begin
                        if (!sts.lcp_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.st_val     = ST_BAD_RANGE;
                        end
                        else
                        begin
                            cmd.lcp_init = 1'b1;
                            state_next   = S_LCP_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_APP_F:
            begin
                if (sts.mm_done)
                begin
                    cmd.app_fwd  = 1'b1;
                    cmd.mm_start = 1'b1;
                    cmd.mm_sel   = MM_POW;
                    state_next   = S_APP_P;
                end
            end
            S_APP_P:
            begin
                if (sts.mm_done)
                begin
                    cmd.app_pow = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_REV_CHK:
            begin
                if (sts.rev_end)
                begin
                    cmd.rev_done = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_REV_RD;
                end
            end
            S_REV_RD:
            begin
                cmd.rev_rd   = 1'b1;
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = MM_REV;
                state_next   = S_REV_MM;
            end
            S_REV_MM:
            begin
                if (sts.mm_done)
                begin
                    cmd.rev_wr = 1'b1;
                    state_next = S_REV_CHK;
                end
            end
            S_RD_LP:
            begin
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.cap_lp = 1'b1;
                cmd.hsel_r = 1'b1;
                state_next = S_MM_R;
            end
            S_MM_R:
            begin
                cmd.cap_r    = 1'b1;
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = MM_RANGE;
                state_next   = S_MM_W;
            end
            S_MM_W:
            begin
                if (sts.mm_done)
                begin
                    cmd.range_save = 1'b1;
                    state_next     = S_POST;
                end
            end
            S_POST:
            begin
                case (phase_reg)
                    PH_Q:
                    begin
                        cmd.set_hash = 1'b1;
                        state_next   = S_DONE;
                    end
                    PH_REV:
                    begin
                        cmd.save_x    = 1'b1;
                        cmd.ld_range  = 1'b1;
                        cmd.range_src = RS_AB;
                        phase_next    = PH_FWD;
                        state_next    = S_RD_LP;
                    end
                    PH_FWD:
                    begin
                        cmd.set_hash = 1'b1;
                        cmd.set_pal  = 1'b1;
                        state_next   = S_DONE;
                    end
                    PH_LA:
                    begin
                        cmd.save_x    = 1'b1;
                        cmd.ld_range  = 1'b1;
                        cmd.range_src = RS_LB;
                        phase_next    = PH_LB;
                        state_next    = S_RD_LP;
                    end
                    default:
                    begin
                        cmd.lcp_upd = 1'b1;
                        state_next  = S_LCP_CHK;
                    end
                endcase
            end
            S_LCP_CHK:
            begin
                if (sts.lcp_more)
                begin
                    cmd.ld_range  = 1'b1;
                    cmd.range_src = RS_LA;
                    phase_next    = PH_LA;
                    state_next    = S_RD_LP;
                end
                else
                begin
                    cmd.set_plen = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/double_rolling_hash_engine.sv
// Top level of the double-modulus rolling hash engine: controller plus datapath.
//
// Input channel (in_valid / in_stall) takes one item: opcode, char_value, pos_a, pos_b.
// Output channel (out_valid / out_stall) gives one result item per input item, in order.
// Configuration: cfg_we writes cfg_wdata into reverse_enable at once; write it while idle.
// One item is worked at a time; in_stall is low only while the controller is idle, and
// the next item may enter while a finished result still waits in the output register,
// so a new item is taken only once the previous result has been loaded for output.
// Processing time is set by the bit-serial modular multipliers (one per modulus, working
// side by side) and the registered memory reads; finish runs one multiply per stored
// byte, and common prefix runs a pair of range hashes per binary search step, up to
// log2(length)+1 steps.
// Reset (rst_n low, asynchronous) empties the string, drops the reverse table, clears
// reverse_enable and the output valid; the hash stores need no clearing pass since
// entry zero of each table is supplied as a constant and nothing unwritten is read.
// When the receiver stalls, the result holds steady in the output register and the
// controller waits with its next result until the register is free.
module double_rolling_hash_engine #(
    parameter int MAX_LEN = dre_pkg::MAX_LEN_DEF,
    localparam int LW     = $clog2(MAX_LEN + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 opcode,
    input  logic [dre_pkg::CHAR_W-1:0] char_value,
    input  logic [LW-1:0]              pos_a,
    input  logic [LW-1:0]              pos_b,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [dre_pkg::HASH_W-1:0] hash_first,
    output logic [dre_pkg::HASH_W-1:0] hash_second,
    output logic                       is_palin,
    output logic [LW-1:0]              prefix_length,
    output logic [1:0]                 status
);
    import dre_pkg::*;

    dre_cmd_t cmd;
    dre_sts_t sts;

    // sequence each item
    dre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores, multipliers and result registers
    dre_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .opcode        (opcode),
        .char_value    (char_value),
        .pos_a         (pos_a),
        .pos_b         (pos_b),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hash_first    (hash_first),
        .hash_second   (hash_second),
        .is_palin      (is_palin),
        .prefix_length (prefix_length),
        .status        (status)
    );

endmodule

// File: test/double_rolling_hash_engine_test.sv
// Self-checking bench for the double rolling hash engine: directed and random items.
module double_rolling_hash_engine_test;

    import dre_pkg::*;

    localparam int          MAX_LEN  = 4096;
    localparam int          PW       = 13;
    localparam logic [2:0]  OP_SPARE_A = 3'd6;
    localparam logic [2:0]  OP_SPARE_B = 3'd7;
    localparam longint      M1 = 64'd1000000007;
    localparam longint      M2 = 64'd1000000009;
    localparam longint      B1 = 64'd1007;
    localparam longint      B2 = 64'd2009;

    typedef struct {
        logic [2:0]    op;
        logic [7:0]    ch;
        logic [PW-1:0] a;
        logic [PW-1:0] b;
    } item_t;

    typedef struct {
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
        logic              pal;
        logic [PW-1:0]     plen;
        st_t               st;
    } hash_res_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [2:0]          opcode;
    logic [7:0]          char_value;
    logic [PW-1:0]       pos_a;
    logic [PW-1:0]       pos_b;
    logic                out_valid;
    logic                out_stall;
    logic [HASH_W-1:0]   hash_first;
    logic [HASH_W-1:0]   hash_second;
    logic                is_palin;
    logic [PW-1:0]       prefix_length;
    logic [1:0]          status;

    double_rolling_hash_engine #(.MAX_LEN(MAX_LEN)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .char_value(char_value), .pos_a(pos_a), .pos_b(pos_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .hash_first(hash_first), .hash_second(hash_second), .is_palin(is_palin),
        .prefix_length(prefix_length), .status(status)
    );

    // Shadow state of the engine: prefix hashes, powers, reverse table, bytes.
    longint unsigned pre1 [0:MAX_LEN];
    longint unsigned pre2 [0:MAX_LEN];
    longint unsigned pw1  [0:MAX_LEN];
    longint unsigned pw2  [0:MAX_LEN];
    longint unsigned rv1  [0:MAX_LEN];
    longint unsigned rv2  [0:MAX_LEN];
    logic [7:0]      bytes_held [0:MAX_LEN-1];
    int              str_len;
    bit              rev_valid;
    bit              rev_en;

    item_t     item_q[$];
    hash_res_t due_q[$];
    int        n_queued;
    int        n_taken;
    int        errors;
    int        gen_len;
    bit        calm;
    bit        took;
    int        send_gap;
    int        stall_gap;
    bit        hold_go;
    bit        hold_done;
    int        hold_left;

    function automatic longint unsigned seg_hash(input bit second, input bit rev,
                                                 input int l, input int r);
        longint unsigned hl, hr, p, m, t;
        m  = second ? M2 : M1;
        p  = second ? pw2[r-l] : pw1[r-l];
        hl = rev ? (second ? rv2[l] : rv1[l]) : (second ? pre2[l] : pre1[l]);
        hr = rev ? (second ? rv2[r] : rv1[r]) : (second ? pre2[r] : pre1[r]);
        t  = (hl * p) % m;
        return (hr + m - t) % m;
    endfunction

    // Advance the shadow state by one item and give the result it must produce.
    function automatic hash_res_t engine_step(input item_t it);
        hash_res_t r;
        int n, a, b, lo, hi, mid;
        longint unsigned c;
        r = '{h1: '0, h2: '0, pal: 1'b0, plen: '0, st: ST_OK};
        n = str_len;
        a = it.a;
        b = it.b;
        if (it.op == OP_CLEAR) begin
            str_len   = 0;
            rev_valid = 0;
        end else if (it.op == OP_APPEND) begin
            if (n >= MAX_LEN) begin
                r.st = ST_FULL;
            end else begin
                bytes_held[n] = it.ch;
                pre1[n+1] = (pre1[n] * B1 + it.ch) % M1;
                pre2[n+1] = (pre2[n] * B2 + it.ch) % M2;
                pw1[n+1]  = (pw1[n] * B1) % M1;
                pw2[n+1]  = (pw2[n] * B2) % M2;
                str_len   = n + 1;
                rev_valid = 0;
            end
        end else if (it.op == OP_FINISH) begin
            if (rev_en) begin
                rv1[0] = 0;
                rv2[0] = 0;
                for (int i = 0; i < n; i++) begin
                    c = bytes_held[n-1-i];
                    rv1[i+1] = (rv1[i] * B1 + c) % M1;
                    rv2[i+1] = (rv2[i] * B2 + c) % M2;
                end
            end
            rev_valid = rev_en;
        end else if (it.op == OP_RANGE || it.op == OP_PALIN) begin
            if (a > b || b > n) begin
                r.st = ST_BAD_RANGE;
            end else if (it.op == OP_PALIN && !rev_valid) begin
                r.st = ST_NO_REVERSE;
            end else begin
                r.h1 = HASH_W'(seg_hash(0, 0, a, b));
                r.h2 = HASH_W'(seg_hash(1, 0, a, b));
                if (it.op == OP_PALIN) begin
                    r.pal = (r.h1 == seg_hash(0, 1, n - b, n - a)) &&
                            (r.h2 == seg_hash(1, 1, n - b, n - a));
                end
            end
        end else if (it.op == OP_LCP) begin
            if (a > n || b > n) begin
                r.st = ST_BAD_RANGE;
            end else begin
                // binary search on hash equality, low starting below zero
                lo = -1;
                hi = n + 1 - (a > b ? a : b);
                while (hi - lo > 1) begin
                    mid = (lo + hi) >>> 1;
                    if (seg_hash(0, 0, a, a + mid) != seg_hash(0, 0, b, b + mid) ||
                        seg_hash(1, 0, a, a + mid) != seg_hash(1, 0, b, b + mid))
                        hi = mid;
                    else
                        lo = mid;
                end
                r.plen = (lo < 0) ? '0 : PW'(lo);
            end
        end
        return r;
    endfunction

    task automatic push_item(input logic [2:0] op, input int ch, input int a, input int b);
        item_t it;
        it.op = op;
        it.ch = 8'(ch);
        it.a  = PW'(a);
        it.b  = PW'(b);
        item_q.push_back(it);
        n_queued++;
        if (op == OP_CLEAR) gen_len = 0;
        if (op == OP_APPEND && gen_len < MAX_LEN) gen_len++;
    endtask

    // Wait until every queued item has gone in and every result has come back.
    task automatic drain();
        wait (n_taken == n_queued && due_q.size() == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_rev_enable(input bit v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        rev_en = v;
    endtask

    function automatic int pick_char();
        return ($urandom_range(0, 1) == 0) ? 97 + $urandom_range(0, 2) : $urandom_range(0, 255);
    endfunction

    function automatic int pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 8191);
        if (r == 1) return gen_len + $urandom_range(1, 3);
        return $urandom_range(0, gen_len);
    endfunction

    // One session: optional clear, a short string (sometimes mirrored), usually a finish, queries.
    task automatic random_session(inout int count);
        int k, q, sel, a, b;
        int mirror[$];
        if ($urandom_range(0, 2) == 0) begin
            push_item(OP_CLEAR, $urandom_range(0, 255), pick_pos(), pick_pos());
            count++;
        end
        k = $urandom_range(0, 14);
        mirror = {};
        for (int i = 0; i < k; i++) begin
            mirror.push_back(pick_char());
            push_item(OP_APPEND, mirror[i], $urandom_range(0, 8191), $urandom_range(0, 8191));
            count++;
        end
        if (k > 0 && $urandom_range(0, 1) == 0) begin
            for (int i = k - 1 - $urandom_range(0, 1); i >= 0; i--) begin
                push_item(OP_APPEND, mirror[i], pick_pos(), pick_pos());
                count++;
            end
        end
        if ($urandom_range(0, 6) != 0) begin
            push_item(OP_FINISH, $urandom_range(0, 255), pick_pos(), pick_pos());
            count++;
        end
        q = $urandom_range(3, 9);
        for (int i = 0; i < q; i++) begin
            sel = $urandom_range(0, 19);
            a = pick_pos();
            b = pick_pos();
            if (sel < 14 && a > b && $urandom_range(0, 3) != 0) begin
                a = a ^ b;
                b = a ^ b;
                a = a ^ b;
            end
            if (sel < 5)       push_item(OP_RANGE, $urandom_range(0, 255), a, b);
            else if (sel < 11) push_item(OP_PALIN, $urandom_range(0, 255), a, b);
            else if (sel < 17) push_item(OP_LCP, $urandom_range(0, 255), a, b);
            else if (sel < 18) push_item(OP_SPARE_A, $urandom_range(0, 255), a, b);
            else if (sel < 19) push_item(OP_SPARE_B, $urandom_range(0, 255), a, b);
            else               push_item(OP_APPEND, pick_char(), a, b);
            count++;
        end
    endtask

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Driver: advance to the next item once the current one is taken; idle in bursts.
    always @(negedge clk) begin
        item_t nx;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || took) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                nx = item_q.pop_front();
                in_valid   <= 1'b1;
                opcode     <= nx.op;
                char_value <= nx.ch;
                pos_a      <= nx.a;
                pos_b      <= nx.b;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 13);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here, so the engine backs up into its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (stall_gap > 0)
                stall_gap <= stall_gap - 1;
            else if (!calm && $urandom_range(0, 7) == 0)
                stall_gap <= $urandom_range(1, 13);
            out_stall <= (hold_left > 0) || (stall_gap > 0);
        end
    end

    // Acceptance on the input side feeds the shadow engine; results checked in order.
    always @(posedge clk) begin
        item_t     it;
        hash_res_t want;
        if (!rst_n) begin
            took <= 1'b0;
        end else begin
            took <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                it.op = opcode;
                it.ch = char_value;
                it.a  = pos_a;
                it.b  = pos_b;
                due_q.push_back(engine_step(it));
                n_taken++;
            end
            if (out_valid && !out_stall) begin
                if (due_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual status %0d",
                             $time, status);
                    errors++;
                end else begin
                    want = due_q.pop_front();
                    if (hash_first !== want.h1) begin
                        $display("%0t: hash_first expected %0d actual %0d",
                                 $time, want.h1, hash_first);
                        errors++;
                    end
                    if (hash_second !== want.h2) begin
                        $display("%0t: hash_second expected %0d actual %0d",
                                 $time, want.h2, hash_second);
                        errors++;
                    end
                    if (is_palin !== want.pal) begin
                        $display("%0t: is_palin expected %0d actual %0d",
                                 $time, want.pal, is_palin);
                        errors++;
                    end
                    if (prefix_length !== want.plen) begin
                        $display("%0t: prefix_length expected %0d actual %0d",
                                 $time, want.plen, prefix_length);
                        errors++;
                    end
                    if (status !== want.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #100000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int count;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = '0;
        char_value = '0;
        pos_a = '0;
        pos_b = '0;
        n_queued = 0;
        n_taken = 0;
        errors = 0;
        gen_len = 0;
        calm = 0;
        hold_go = 0;
        str_len = 0;
        rev_valid = 0;
        rev_en = 0;
        pre1[0] = 0;
        pre2[0] = 0;
        pw1[0] = 1;
        pw2[0] = 1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty store, spare opcodes, extremes of bytes and positions.
        write_rev_enable(1'b0);
        push_item(OP_CLEAR, 0, 0, 0);
        push_item(OP_SPARE_A, 255, 8191, 8191);
        push_item(OP_SPARE_B, 170, 4096, 1);
        push_item(OP_PALIN, 0, 0, 0);
        push_item(OP_LCP, 0, 0, 0);
        push_item(OP_APPEND, 0, 8191, 8191);
        push_item(OP_APPEND, 255, 0, 0);
        push_item(OP_APPEND, 0, 0, 0);
        push_item(OP_RANGE, 0, 0, 3);
        push_item(OP_RANGE, 0, 2, 1);
        push_item(OP_RANGE, 0, 0, 4);
        push_item(OP_LCP, 0, 0, 2);
        push_item(OP_LCP, 0, 8191, 0);
        push_item(OP_FINISH, 0, 0, 0);
        push_item(OP_PALIN, 0, 0, 3);
        drain();
        write_rev_enable(1'b1);
        push_item(OP_FINISH, 0, 0, 0);
        push_item(OP_PALIN, 0, 0, 3);
        push_item(OP_PALIN, 0, 0, 2);
        push_item(OP_PALIN, 0, 3, 3);
        push_item(OP_PALIN, 0, 4, 2);
        push_item(OP_APPEND, 255, 0, 0);
        push_item(OP_PALIN, 0, 0, 4);
        push_item(OP_FINISH, 0, 0, 0);
        push_item(OP_PALIN, 0, 1, 3);
        push_item(OP_CLEAR, 0, 0, 0);
        push_item(OP_FINISH, 0, 0, 0);
        push_item(OP_PALIN, 0, 0, 0);
        drain();

        // Fill the store to the brim, then knock on it when full.
        write_rev_enable(1'b0);
        for (int i = 0; i < MAX_LEN; i++)
            push_item(OP_APPEND, (i % 7 == 0) ? 97 : $urandom_range(0, 255), 0, 0);
        push_item(OP_APPEND, 1, 0, 0);
        push_item(OP_APPEND, 2, 0, 0);
        push_item(OP_RANGE, 0, 0, 4096);
        push_item(OP_RANGE, 0, 4095, 4096);
        push_item(OP_RANGE, 0, 0, 4097);
        push_item(OP_LCP, 0, 0, 7);
        push_item(OP_LCP, 0, 4096, 4096);
        push_item(OP_PALIN, 0, 0, 4096);
        push_item(OP_CLEAR, 0, 0, 0);
        drain();

        // Random sessions over several register settings; quiet at the end.
        count = 0;
        for (int seg = 0; seg < 5; seg++) begin
            write_rev_enable(seg == 0 || seg == 4 ? 1'b1 : $urandom_range(0, 1));
            if (seg == 4) calm = 1;
            while (count < (seg + 1) * 240) begin
                random_session(count);
                if (seg == 0 && count > 60) hold_go = 1;
            end
            drain();
        end

        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
